// ===== src/nsn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsn_pkg;

  // Value and result field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int NB_W    = 6;

  // Neighbour code for "no smaller element"
  localparam logic signed [NB_W-1:0] NB_NONE = '1;

  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  // Which result the datapath builds when told to emit
  typedef enum logic [1:0] {
    SEL_LEFT  = 2'd0,
    SEL_RIGHT = 2'd1,
    SEL_FLUSH = 2'd2,
    SEL_DROP  = 2'd3
  } emit_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic      load_in;
    logic      pop_l;
    logic      pop_r;
    logic      push;
    logic      emit;
    emit_sel_t sel;
    logic      end_run;
    logic      clear;
  } nsn_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;      // sequence already at maximum length
    logic lpop;      // left top is not strictly smaller than the new value
    logic rpop;      // new value is strictly smaller than the right top
    logic rempty;
    logic rlast;     // one entry left on the right stack
    logic out_free;  // output register can take a result this cycle
    logic last;
  } nsn_stat_t;

endpackage

`default_nettype wire

// ===== src/nsn_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one sequence element per transaction
interface nsn_in_if import nsn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// Result channel: one answer per transaction
interface nsn_out_if import nsn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic [POS_W-1:0]       position;
  logic signed [NB_W-1:0] neighbour;
  logic                   end_of_run;

  modport source (output valid, kind, position, neighbour, end_of_run, input ready);
  modport sink   (input valid, kind, position, neighbour, end_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/nsn_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module nsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/nsn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsn_ctrl import nsn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire nsn_stat_t st,
  output nsn_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WAIT  = 6'b000010,  // stack tops being read
    S_EVAL  = 6'b000100,  // compare tops, pop or finish the element
    S_DROP  = 6'b001000,
    S_FWAIT = 6'b010000,  // right top being read during flush
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.sel     = SEL_LEFT;
    cmd.load_in = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = st.full ? S_DROP : S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (st.rpop) begin
          if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.sel   = SEL_RIGHT;
            cmd.pop_r = 1'b1;
            cmd.pop_l = st.lpop;
            state_nxt = S_WAIT;
          end
        end else if (st.lpop) begin
          cmd.pop_l = 1'b1;
          state_nxt = S_WAIT;
        end else if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_LEFT;
          cmd.end_run = !st.last;
          cmd.push    = 1'b1;
          state_nxt   = st.last ? S_FWAIT : S_IDLE;
        end
      end
      S_DROP: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_DROP;
          cmd.end_run = !st.last;
          state_nxt   = st.last ? S_FWAIT : S_IDLE;
        end
      end
      S_FWAIT: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        priority if (st.rempty) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_FLUSH;
          cmd.pop_r   = 1'b1;
          cmd.end_run = st.rlast;
          cmd.clear   = st.rlast;
          state_nxt   = st.rlast ? S_IDLE : S_FWAIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An item arriving on a full sequence is dropped, never pushed
  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st.full) |=> (state_r == S_DROP))
    else $error("full sequence did not lead to drop");

endmodule

`default_nettype wire

// ===== src/nsn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsn_dp import nsn_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      in_last,
  input  wire nsn_cmd_t                  cmd,
  output nsn_stat_t                      st,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output kind_t                          out_kind,
  output logic [POS_W-1:0]               out_position,
  output logic signed [NB_W-1:0]         out_neighbour,
  output logic                           out_end_of_run
);

  localparam int IW = $clog2(MAX_LEN);      // stack address / position index
  localparam int CW = $clog2(MAX_LEN + 1);  // stack depth counters
  localparam int EW = VALUE_W + IW;         // stack entry: {value, position}

  logic [CW-1:0]              lcnt_r, lcnt_nxt;
  logic [CW-1:0]              rcnt_r, rcnt_nxt;
  logic [CW-1:0]              npos_r, npos_nxt;
  logic signed [VALUE_W-1:0]  val_r;
  logic                       last_r;

  logic [EW-1:0]              l_rd, r_rd, push_data;
  logic signed [VALUE_W-1:0]  l_val, r_val;
  logic [IW-1:0]              l_pos, r_pos;
  logic [IW-1:0]              l_raddr, r_raddr;
  logic [CW-1:0]              l_dec, r_dec;

  logic                       out_valid_r, out_valid_nxt;
  kind_t                      kind_r;
  logic [POS_W-1:0]           pos_r;
  logic signed [NB_W-1:0]     nb_r;
  logic                       eor_r;

  // Stacks hold value and position together; read port always on the top
  assign l_dec     = lcnt_r - CW'(1);
  assign r_dec     = rcnt_r - CW'(1);
  assign l_raddr   = l_dec[IW-1:0];
  assign r_raddr   = r_dec[IW-1:0];
  assign push_data = {val_r, npos_r[IW-1:0]};

  nsn_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_left_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (lcnt_r[IW-1:0]),
    .wdata (push_data),
    .raddr (l_raddr),
    .rdata (l_rd)
  );

  nsn_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_right_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (rcnt_r[IW-1:0]),
    .wdata (push_data),
    .raddr (r_raddr),
    .rdata (r_rd)
  );

  assign l_val = l_rd[EW-1:IW];
  assign l_pos = l_rd[IW-1:0];
  assign r_val = r_rd[EW-1:IW];
  assign r_pos = r_rd[IW-1:0];

  // Status for the controller
  always_comb begin
    st.full     = (npos_r == CW'(MAX_LEN));
    st.lpop     = (lcnt_r != '0) && !(l_val < val_r);
    st.rpop     = (rcnt_r != '0) && (val_r < r_val);
    st.rempty   = (rcnt_r == '0);
    st.rlast    = (rcnt_r == CW'(1));
    st.out_free = !out_valid_r || out_ready;
    st.last     = last_r;
  end

  // Stack depths and next position
  always_comb begin
    lcnt_nxt = lcnt_r;
    rcnt_nxt = rcnt_r;
    npos_nxt = npos_r;
    priority if (cmd.clear) begin
      lcnt_nxt = '0;
      rcnt_nxt = '0;
      npos_nxt = '0;
    end else if (cmd.push) begin
      lcnt_nxt = lcnt_r + CW'(1);
      rcnt_nxt = rcnt_r + CW'(1);
      npos_nxt = npos_r + CW'(1);
    end else begin
      if (cmd.pop_l) begin
        lcnt_nxt = l_dec;
      end
      if (cmd.pop_r) begin
        rcnt_nxt = r_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      rcnt_r <= '0;
      npos_r <= '0;
    end else begin
      lcnt_r <= lcnt_nxt;
      rcnt_r <= rcnt_nxt;
      npos_r <= npos_nxt;
    end
  end

  // Input element held for the whole item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r  <= in_value;
      last_r <= in_last;
    end
  end

  // Output register
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      eor_r <= cmd.end_run;
      unique case (cmd.sel)
        SEL_LEFT: begin
          kind_r <= KIND_LEFT;
          pos_r  <= POS_W'(npos_r);
          nb_r   <= (lcnt_r != '0) ? NB_W'(l_pos) : NB_NONE;
        end
        SEL_RIGHT: begin
          kind_r <= KIND_RIGHT;
          pos_r  <= POS_W'(r_pos);
          nb_r   <= NB_W'(npos_r);
        end
        SEL_FLUSH: begin
          kind_r <= KIND_RIGHT;
          pos_r  <= POS_W'(r_pos);
          nb_r   <= NB_NONE;
        end
        SEL_DROP: begin
          kind_r <= KIND_DROP;
          pos_r  <= '0;
          nb_r   <= NB_NONE;
        end
        default: begin
          kind_r <= KIND_DROP;
          pos_r  <= '0;
          nb_r   <= NB_NONE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_position   = pos_r;
  assign out_neighbour  = nb_r;
  assign out_end_of_run = eor_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (npos_r < CW'(MAX_LEN)))
    else $error("push beyond maximum length");

  a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= npos_r)
    else $error("right stack deeper than sequence");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrites one not yet taken");

endmodule

`default_nettype wire

// ===== src/nearest_smaller_neighbours.sv =====
// Channel   Dir   Payload                                   Transaction
// in_ch     in    value[31:0] signed, last                  valid && ready
// out_ch    out   kind[1:0], position[4:0],                 valid && ready
//                 neighbour[5:0] signed, end_of_run
//
// One element at a time: the element is accepted, then each stack-top check
// reads the tops from RAM (S_WAIT) and then compares them (S_EVAL), popping
// as needed; a flush reads and pops each waiting position in turn (S_FWAIT,
// S_FLUSH), the last one also clearing the stacks.
// The registered read of the stack RAMs is why each check has a read step.
// Synchronous active-low reset empties both stacks; no clearing pass.
// A stalled out_ch holds the controller before its next result; in_ch is
// taken again only after the previous item is finished.
`timescale 1ns / 1ps
`default_nettype none

module nearest_smaller_neighbours import nsn_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nsn_in_if.sink     in_ch,
  nsn_out_if.source  out_ch
);

  nsn_cmd_t  cmd;
  nsn_stat_t st;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  nsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  nsn_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_ch.value),
    .in_last        (in_ch.last),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_position   (out_ch.position),
    .out_neighbour  (out_ch.neighbour),
    .out_end_of_run (out_ch.end_of_run)
  );

endmodule

`default_nettype wire

// ===== tb/sv/nsn_answer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own pair of position stacks and compares
// every answer the block returns with the oldest one predicted.
module nsn_answer_checker import nsn_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  logic clk,
  input  logic rst_n,
  nsn_in_if    in_mon,
  nsn_out_if   out_mon,
  output int   errors,
  output int   outstanding,
  output int   answers_seen,
  output int   drops_seen
);

  typedef logic signed [VALUE_W-1:0] elem_t;

  typedef struct packed {
    kind_t                  kind;
    logic [POS_W-1:0]       position;
    logic signed [NB_W-1:0] neighbour;
    logic                   end_of_run;
  } answer_t;

  // Predictor state: element values, the ascending stack used for left
  // answers and the stack of positions still waiting for a right answer
  elem_t       seq_vals[MAX_LEN];
  int unsigned asc_stack[MAX_LEN];
  int unsigned wait_stack[MAX_LEN];
  int unsigned asc_depth;
  int unsigned wait_depth;
  int unsigned seq_len;

  answer_t expected_answers[$];
  int      mismatch_count = 0;
  int      checked_count  = 0;
  int      drop_count     = 0;

  assign errors       = mismatch_count;
  assign outstanding  = expected_answers.size();
  assign answers_seen = checked_count;
  assign drops_seen   = drop_count;

  function automatic answer_t make_answer(kind_t k, int unsigned pos,
                                          logic signed [NB_W-1:0] nb);
    answer_t a;
    a.kind       = k;
    a.position   = pos[POS_W-1:0];
    a.neighbour  = nb;
    a.end_of_run = 1'b0;
    return a;
  endfunction

  // Works out every answer one accepted element causes, in output order
  task automatic predict_neighbours(input elem_t v, input logic is_last);
    answer_t                batch[$];
    int unsigned            pos;
    logic signed [NB_W-1:0] left_nb;
    if (seq_len >= MAX_LEN) begin
      // sequence already full: element dropped, state untouched
      batch.push_back(make_answer(KIND_DROP, 0, NB_NONE));
    end else begin
      pos = seq_len;
      // equal values are not smaller, so they leave the ascending stack too
      while (asc_depth > 0 && seq_vals[asc_stack[asc_depth-1]] >= v)
        asc_depth--;
      while (wait_depth > 0 && v < seq_vals[wait_stack[wait_depth-1]]) begin
        batch.push_back(make_answer(KIND_RIGHT, wait_stack[wait_depth-1], NB_W'(pos)));
        wait_depth--;
      end
      left_nb = NB_NONE;
      if (asc_depth > 0)
        left_nb = NB_W'(asc_stack[asc_depth-1]);
      batch.push_back(make_answer(KIND_LEFT, pos, left_nb));
      seq_vals[pos]          = v;
      asc_stack[asc_depth]   = pos;
      wait_stack[wait_depth] = pos;
      asc_depth++;
      wait_depth++;
      seq_len++;
    end
    // end of sequence: everything still waiting has no smaller right value
    if (is_last) begin
      while (wait_depth > 0) begin
        batch.push_back(make_answer(KIND_RIGHT, wait_stack[wait_depth-1], NB_NONE));
        wait_depth--;
      end
      asc_depth = 0;
      seq_len   = 0;
    end
    batch[batch.size()-1].end_of_run = 1'b1;
    foreach (batch[i])
      expected_answers.push_back(batch[i]);
  endtask

  // Only the first few dozen lines are printed; all mismatches are counted
  task automatic report_mismatch(input string what);
    if (mismatch_count < 40)
      $display("[%0t] answer mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_answer();
    answer_t exp;
    if (expected_answers.size() == 0) begin
      report_mismatch($sformatf("unexpected answer kind %0d position %0d neighbour %0d",
                                out_mon.kind, out_mon.position, out_mon.neighbour));
      return;
    end
    exp = expected_answers.pop_front();
    checked_count++;
    if (exp.kind == KIND_DROP)
      drop_count++;
    if (out_mon.kind !== exp.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_mon.kind, exp.kind));
    if (out_mon.position !== exp.position)
      report_mismatch($sformatf("position %0d, expected %0d",
                                out_mon.position, exp.position));
    if (out_mon.neighbour !== exp.neighbour)
      report_mismatch($sformatf("neighbour %0d, expected %0d (position %0d)",
                                out_mon.neighbour, exp.neighbour, exp.position));
    if (out_mon.end_of_run !== exp.end_of_run)
      report_mismatch($sformatf("end_of_run %b, expected %b (position %0d)",
                                out_mon.end_of_run, exp.end_of_run, exp.position));
  endtask

  // Inputs are predicted before outputs are checked within one edge
  always @(posedge clk) begin
    if (!rst_n) begin
      asc_depth  = 0;
      wait_depth = 0;
      seq_len    = 0;
      expected_answers.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_neighbours(in_mon.value, in_mon.last);
      if (out_mon.valid && out_mon.ready)
        check_answer();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nsn_pkg::*;

  localparam int SEQ_MAX      = 32;
  localparam int TARGET_ITEMS = 500;
  localparam int DRAIN_LIMIT  = 20000;

  typedef logic signed [VALUE_W-1:0] elem_t;

  // How the values of one random sequence are chosen
  typedef enum int {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_RISING,
    STYLE_FALLING,
    STYLE_EXTREME
  } style_t;

  logic clk;
  logic rst_n;

  nsn_in_if  in_ch();
  nsn_out_if out_ch();

  int mismatches;
  int outstanding;
  int answers_checked;
  int drops_checked;

  int elements_sent     = 0;
  int sequences_sent    = 0;
  int overrun_sequences = 0;
  int burst_left        = 1;
  bit steady_sender     = 1'b1;

  nearest_smaller_neighbours #(.MAX_LEN(SEQ_MAX)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nsn_answer_checker #(.MAX_LEN(SEQ_MAX)) answer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .errors       (mismatches),
    .outstanding  (outstanding),
    .answers_seen (answers_checked),
    .drops_seen   (drops_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: ready follows a pattern that a running cycle counter picks in turn
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      case (rx_cycle[9:8])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ch.ready <= (rx_cycle[2:0] < 3'd5);
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // One transaction; the sender idles between bursts unless running steady
  task automatic send_element(input elem_t v, input logic is_last);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    elements_sent++;
    if (!steady_sender) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        in_ch.value <= elem_t'($urandom);
        in_ch.last  <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  task automatic send_sequence(input elem_t vals[$]);
    foreach (vals[i])
      send_element(vals[i], i == vals.size() - 1);
    sequences_sent++;
    if (vals.size() > SEQ_MAX)
      overrun_sequences++;
  endtask

  function automatic elem_t pick_value(input style_t style, input elem_t prev);
    case (style)
      STYLE_WIDE:    return elem_t'($urandom);
      STYLE_NARROW:  return elem_t'($urandom_range(0, 6)) - elem_t'(3);
      STYLE_RISING:  return prev + elem_t'($urandom_range(0, 3));
      STYLE_FALLING: return prev - elem_t'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 0;
          3: return -1;
          default: return elem_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Mostly short sequences; about one in six runs near or past the limit
  task automatic send_random_sequence(input int forced_len);
    elem_t  run[$];
    elem_t  v;
    int     len;
    style_t style;
    len = forced_len;
    if (len == 0)
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(SEQ_MAX - 2, SEQ_MAX + 4)
                                        : $urandom_range(1, 12);
    style         = style_t'($urandom_range(0, 4));
    steady_sender = ($urandom_range(0, 3) == 0);
    v             = elem_t'($urandom_range(0, 200)) - elem_t'(100);
    for (int i = 0; i < len; i++) begin
      v = pick_value(style, v);
      run.push_back(v);
    end
    send_sequence(run);
  endtask

  initial begin
    elem_t run[$];
    int    drain;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, equal values, single element, monotone runs
    run = {32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_sequence(run);
    run = {5, 5, 5, 5};
    send_sequence(run);
    run = {9};
    send_sequence(run);
    run = {1, 2, 3, 4, 5};
    send_sequence(run);
    run = {5, 4, 3, 2, 1};
    send_sequence(run);
    run = {3, 1, 4, 1};
    send_sequence(run);

    // Random: first one overflows and ends on a dropped element
    send_random_sequence(SEQ_MAX + 2);
    while (elements_sent < TARGET_ITEMS)
      send_random_sequence(0);
    in_ch.valid <= 1'b0;

    // Let every answer come back, then watch for stray ones
    drain = 0;
    while (outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (100) @(negedge clk);

    $display("Sent %0d elements in %0d sequences, %0d of them past the length limit.",
             elements_sent, sequences_sent, overrun_sequences);
    $display("Checked %0d answers, %0d of them overflow drops.",
             answers_checked, drops_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      if (outstanding != 0)
        $display("%0d expected answers never arrived", outstanding);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/nsn_pkg.sv
src/nsn_if.sv
src/nsn_ram.sv
src/nsn_ctrl.sv
src/nsn_dp.sv
src/nearest_smaller_neighbours.sv
tb/sv/nsn_answer_checker.sv
tb/sv/testbench.sv
